### rtl/fgn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg
// Shared constants, hash tables and arithmetic helpers for the fractal
// gradient noise pipeline.
// ----------------------------------------------------------------------------
package fgn_pkg;

    localparam int DEF_MAX_OCTAVES = 8;
    localparam int POS_W  = 32;
    localparam int PROD_W = 40;
    localparam int FRAC_W = 16;
    localparam int CELL_W = 8;
    localparam int OFS_W  = 18;
    localparam int NV_W   = 19;
    localparam int FADE_W = 20;
    localparam int FREQ_W = 24;
    localparam int AMP_W  = 16;
    localparam int CNT_W  = 4;
    localparam int GAIN_W = 16;
    localparam int SEED_W = 8;
    localparam int OUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_AMPLITUDE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PER_OCTAVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_BYTE       = 3'd4;

    localparam logic [FREQ_W-1:0] RST_BASE_FREQUENCY  = 24'd65536;
    localparam logic [AMP_W-1:0]  RST_BASE_AMPLITUDE  = 16'd4096;
    localparam logic [CNT_W-1:0]  RST_OCTAVE_COUNT    = 4'd4;
    localparam logic [GAIN_W-1:0] RST_GAIN_PER_OCTAVE = 16'd32768;
    localparam logic [SEED_W-1:0] RST_SEED_BYTE       = 8'd0;

    typedef struct packed {
        logic sat;
        logic zero;
    } div_flags_t;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd23, 8'd125, 8'd161, 8'd52, 8'd103, 8'd117, 8'd70, 8'd37,
        8'd247, 8'd101, 8'd203, 8'd169, 8'd124, 8'd126, 8'd44, 8'd123,
        8'd152, 8'd238, 8'd145, 8'd45, 8'd171, 8'd114, 8'd253, 8'd10,
        8'd192, 8'd136, 8'd4, 8'd157, 8'd249, 8'd30, 8'd35, 8'd72,
        8'd175, 8'd63, 8'd77, 8'd90, 8'd181, 8'd16, 8'd96, 8'd111,
        8'd133, 8'd104, 8'd75, 8'd162, 8'd93, 8'd56, 8'd66, 8'd240,
        8'd8, 8'd50, 8'd84, 8'd229, 8'd49, 8'd210, 8'd173, 8'd239,
        8'd141, 8'd1, 8'd87, 8'd18, 8'd2, 8'd198, 8'd143, 8'd57,
        8'd225, 8'd160, 8'd58, 8'd217, 8'd168, 8'd206, 8'd245, 8'd204,
        8'd199, 8'd6, 8'd73, 8'd60, 8'd20, 8'd230, 8'd211, 8'd233,
        8'd94, 8'd200, 8'd88, 8'd9, 8'd74, 8'd155, 8'd33, 8'd15,
        8'd219, 8'd130, 8'd226, 8'd202, 8'd83, 8'd236, 8'd42, 8'd172,
        8'd165, 8'd218, 8'd55, 8'd222, 8'd46, 8'd107, 8'd98, 8'd154,
        8'd109, 8'd67, 8'd196, 8'd178, 8'd127, 8'd158, 8'd13, 8'd243,
        8'd65, 8'd79, 8'd166, 8'd248, 8'd25, 8'd224, 8'd115, 8'd80,
        8'd68, 8'd51, 8'd184, 8'd128, 8'd232, 8'd208, 8'd151, 8'd122,
        8'd26, 8'd212, 8'd105, 8'd43, 8'd179, 8'd213, 8'd235, 8'd148,
        8'd146, 8'd89, 8'd14, 8'd195, 8'd28, 8'd78, 8'd112, 8'd76,
        8'd250, 8'd47, 8'd24, 8'd251, 8'd140, 8'd108, 8'd186, 8'd190,
        8'd228, 8'd170, 8'd183, 8'd139, 8'd39, 8'd188, 8'd244, 8'd246,
        8'd132, 8'd48, 8'd119, 8'd144, 8'd180, 8'd138, 8'd134, 8'd193,
        8'd82, 8'd182, 8'd120, 8'd121, 8'd86, 8'd220, 8'd209, 8'd3,
        8'd91, 8'd241, 8'd149, 8'd85, 8'd205, 8'd150, 8'd113, 8'd216,
        8'd31, 8'd100, 8'd41, 8'd164, 8'd177, 8'd214, 8'd153, 8'd231,
        8'd38, 8'd71, 8'd185, 8'd174, 8'd97, 8'd201, 8'd29, 8'd95,
        8'd7, 8'd92, 8'd54, 8'd254, 8'd191, 8'd118, 8'd34, 8'd221,
        8'd131, 8'd11, 8'd163, 8'd99, 8'd234, 8'd81, 8'd227, 8'd147,
        8'd156, 8'd176, 8'd17, 8'd142, 8'd69, 8'd12, 8'd110, 8'd62,
        8'd27, 8'd255, 8'd0, 8'd194, 8'd59, 8'd116, 8'd242, 8'd252,
        8'd19, 8'd21, 8'd187, 8'd53, 8'd207, 8'd129, 8'd64, 8'd135,
        8'd61, 8'd40, 8'd167, 8'd237, 8'd102, 8'd223, 8'd106, 8'd159,
        8'd197, 8'd189, 8'd215, 8'd137, 8'd36, 8'd32, 8'd22, 8'd5
    };

    localparam logic [3:0] GSEL_ROM [256] = '{
        4'd7, 4'd9, 4'd5, 4'd0, 4'd11, 4'd1, 4'd6, 4'd9,
        4'd3, 4'd9, 4'd11, 4'd1, 4'd8, 4'd10, 4'd4, 4'd7,
        4'd8, 4'd6, 4'd1, 4'd5, 4'd3, 4'd10, 4'd9, 4'd10,
        4'd0, 4'd8, 4'd4, 4'd1, 4'd5, 4'd2, 4'd7, 4'd8,
        4'd7, 4'd11, 4'd9, 4'd10, 4'd1, 4'd0, 4'd4, 4'd7,
        4'd5, 4'd0, 4'd11, 4'd6, 4'd1, 4'd4, 4'd2, 4'd8,
        4'd8, 4'd10, 4'd4, 4'd9, 4'd9, 4'd2, 4'd5, 4'd7,
        4'd9, 4'd1, 4'd7, 4'd2, 4'd2, 4'd6, 4'd11, 4'd5,
        4'd5, 4'd4, 4'd6, 4'd9, 4'd0, 4'd1, 4'd1, 4'd0,
        4'd7, 4'd6, 4'd9, 4'd8, 4'd4, 4'd10, 4'd3, 4'd1,
        4'd2, 4'd8, 4'd8, 4'd9, 4'd10, 4'd11, 4'd5, 4'd11,
        4'd11, 4'd2, 4'd6, 4'd10, 4'd3, 4'd4, 4'd2, 4'd4,
        4'd9, 4'd10, 4'd3, 4'd2, 4'd6, 4'd3, 4'd6, 4'd10,
        4'd5, 4'd3, 4'd4, 4'd10, 4'd11, 4'd2, 4'd9, 4'd11,
        4'd1, 4'd11, 4'd10, 4'd4, 4'd9, 4'd4, 4'd11, 4'd0,
        4'd4, 4'd11, 4'd4, 4'd0, 4'd0, 4'd0, 4'd7, 4'd6,
        4'd10, 4'd4, 4'd1, 4'd3, 4'd11, 4'd5, 4'd3, 4'd4,
        4'd2, 4'd9, 4'd1, 4'd3, 4'd0, 4'd1, 4'd8, 4'd0,
        4'd6, 4'd7, 4'd8, 4'd7, 4'd0, 4'd4, 4'd6, 4'd10,
        4'd8, 4'd2, 4'd3, 4'd11, 4'd11, 4'd8, 4'd0, 4'd2,
        4'd4, 4'd8, 4'd3, 4'd0, 4'd0, 4'd10, 4'd6, 4'd1,
        4'd2, 4'd2, 4'd4, 4'd5, 4'd6, 4'd0, 4'd1, 4'd3,
        4'd11, 4'd9, 4'd5, 4'd5, 4'd9, 4'd6, 4'd9, 4'd8,
        4'd3, 4'd8, 4'd1, 4'd8, 4'd9, 4'd6, 4'd9, 4'd11,
        4'd10, 4'd7, 4'd5, 4'd6, 4'd5, 4'd9, 4'd1, 4'd3,
        4'd7, 4'd0, 4'd2, 4'd10, 4'd11, 4'd2, 4'd6, 4'd1,
        4'd3, 4'd11, 4'd7, 4'd7, 4'd2, 4'd1, 4'd7, 4'd3,
        4'd0, 4'd8, 4'd1, 4'd1, 4'd5, 4'd0, 4'd6, 4'd10,
        4'd11, 4'd11, 4'd0, 4'd2, 4'd7, 4'd0, 4'd10, 4'd8,
        4'd3, 4'd5, 4'd7, 4'd1, 4'd11, 4'd1, 4'd0, 4'd7,
        4'd9, 4'd0, 4'd11, 4'd5, 4'd10, 4'd3, 4'd2, 4'd3,
        4'd5, 4'd9, 4'd7, 4'd9, 4'd8, 4'd4, 4'd6, 4'd5
    };

    // dot product of the edge gradient chosen by sel (values 0 to 11) with a corner offset
    function automatic logic signed [NV_W-1:0] grad_dot(
        input logic [3:0]             sel,
        input logic signed [OFS_W-1:0] dx,
        input logic signed [OFS_W-1:0] dy,
        input logic signed [OFS_W-1:0] dz
    );
        logic signed [NV_W-1:0] ex;
        logic signed [NV_W-1:0] ey;
        logic signed [NV_W-1:0] ez;
        logic signed [NV_W-1:0] r;
        ex = {dx[OFS_W-1], dx};
        ey = {dy[OFS_W-1], dy};
        ez = {dz[OFS_W-1], dz};
        case (sel)
            4'd0:    r = ex + ey;
            4'd1:    r = ey - ex;
            4'd2:    r = ex - ey;
            4'd3:    r = -ex - ey;
            4'd4:    r = ex + ez;
            4'd5:    r = ez - ex;
            4'd6:    r = ex - ez;
            4'd7:    r = -ex - ez;
            4'd8:    r = ey + ez;
            4'd9:    r = ez - ey;
            4'd10:   r = ey - ez;
            4'd11:   r = -ey - ez;
            default: r = '0;
        endcase
        return r;
    endfunction

    // 6t^2 - 15t + 10 in Q.16
    function automatic logic [FADE_W-1:0] fade_base(
        input logic [FRAC_W-1:0]   t,
        input logic [2*FRAC_W-1:0] tsq
    );
        logic [35:0] acc;
        acc = (36'd10 << 32) + 36'd6 * {4'b0, tsq} - (({20'b0, t} * 36'd15) << 16);
        return acc[35:16];
    endfunction

    function automatic logic [FADE_W-1:0] fade_step(
        input logic [FADE_W-1:0] q,
        input logic [FRAC_W-1:0] t
    );
        logic [35:0] m;
        m = {16'b0, q} * {20'b0, t};
        return m[35:16];
    endfunction

    // a + floor((b - a) * w / 65536)
    function automatic logic signed [NV_W-1:0] blend(
        input logic signed [NV_W-1:0] a,
        input logic signed [NV_W-1:0] b,
        input logic [FRAC_W-1:0]      w
    );
        logic signed [NV_W:0]    diff;
        logic signed [NV_W+17:0] prod;
        logic signed [NV_W+17:0] sh;
        diff = {b[NV_W-1], b} - {a[NV_W-1], a};
        prod = diff * $signed({1'b0, w});
        sh   = prod >>> 16;
        return a + sh[NV_W-1:0];
    endfunction

endpackage

### rtl/fgn_octave_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_octave_cell
// One octave of gradient noise: hash, gradient dot, fade, trilinear blend
// and weighted accumulation, nine register stages deep.
// ----------------------------------------------------------------------------
module fgn_octave_cell #(
    parameter int CELL_IDX = 0,
    parameter int TOT_W    = 37,
    parameter int ASUM_W   = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic [fgn_pkg::SEED_W-1:0]  seed,
    input  logic [fgn_pkg::GAIN_W-1:0]  gain,
    input  logic                        in_valid,
    input  logic [fgn_pkg::PROD_W-1:0]  in_px,
    input  logic [fgn_pkg::PROD_W-1:0]  in_py,
    input  logic [fgn_pkg::PROD_W-1:0]  in_pz,
    input  logic [TOT_W-1:0]            in_total,
    input  logic [ASUM_W-1:0]           in_asum,
    input  logic [fgn_pkg::AMP_W-1:0]   in_amp,
    output logic                        out_valid,
    output logic [fgn_pkg::PROD_W-1:0]  out_px,
    output logic [fgn_pkg::PROD_W-1:0]  out_py,
    output logic [fgn_pkg::PROD_W-1:0]  out_pz,
    output logic [TOT_W-1:0]            out_total,
    output logic [ASUM_W-1:0]           out_asum,
    output logic [fgn_pkg::AMP_W-1:0]   out_amp
);

    localparam int DEPTH = 9;
    localparam int FW = fgn_pkg::FRAC_W;
    localparam int NW = fgn_pkg::NV_W;

    logic                       vld_reg   [DEPTH];
    logic [fgn_pkg::PROD_W-1:0] px_reg    [DEPTH-1];
    logic [fgn_pkg::PROD_W-1:0] py_reg    [DEPTH-1];
    logic [fgn_pkg::PROD_W-1:0] pz_reg    [DEPTH-1];
    logic [TOT_W-1:0]           total_reg [DEPTH-1];
    logic [ASUM_W-1:0]          asum_reg  [DEPTH-1];
    logic [fgn_pkg::AMP_W-1:0]  amp_reg   [DEPTH-1];

    logic [fgn_pkg::PROD_W-1:0] in_p [3];

    logic [FW-1:0]                  tp_reg  [4][3];
    logic [fgn_pkg::CELL_W-1:0]     cell_reg [3];
    logic [2*FW-1:0]                tsq_reg [3];
    logic [7:0]                     ha_reg  [2];
    logic [7:0]                     hb_reg  [4];
    logic [7:0]                     cz_reg;
    logic [7:0]                     hc_reg  [8];
    logic [fgn_pkg::FADE_W-1:0]     q1_reg  [3];
    logic [fgn_pkg::FADE_W-1:0]     q2_reg  [3];
    logic [fgn_pkg::FADE_W-1:0]     q3_reg  [3];
    logic [FW-1:0]                  f_reg   [3];
    logic [FW-1:0]                  fv_reg;
    logic [FW-1:0]                  fu_reg  [2];
    logic signed [NW-1:0]           dot_reg [8];
    logic signed [NW-1:0]           dot5_reg [8];
    logic signed [NW-1:0]           bz_reg  [4];
    logic signed [NW-1:0]           by_reg  [2];
    logic signed [NW-1:0]           n_reg;

    logic [NW-1:0]                  mag;
    logic [34:0]                    wprod;
    logic [31:0]                    aprod;
    logic [TOT_W-1:0]               total_next;
    logic [ASUM_W-1:0]              asum_next;
    logic [fgn_pkg::AMP_W-1:0]      amp_next;

    assign in_p[0] = in_px;
    assign in_p[1] = in_py;
    assign in_p[2] = in_pz;

    always_comb
    begin
        mag   = n_reg[NW-1] ? NW'(-n_reg) : NW'(n_reg);
        wprod = {16'b0, mag} * {19'b0, amp_reg[DEPTH-2]};
        aprod = {16'b0, amp_reg[DEPTH-2]} * {16'b0, gain};
        amp_next = aprod[31:16];
        if (enable)
        begin
            total_next = total_reg[DEPTH-2] + TOT_W'(wprod);
            asum_next  = asum_reg[DEPTH-2] + ASUM_W'(amp_reg[DEPTH-2]);
        end
        else
        begin
            total_next = total_reg[DEPTH-2];
            asum_next  = asum_reg[DEPTH-2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j < DEPTH; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // carried payload
        px_reg[0]    <= in_px;
        py_reg[0]    <= in_py;
        pz_reg[0]    <= in_pz;
        total_reg[0] <= in_total;
        asum_reg[0]  <= in_asum;
        amp_reg[0]   <= in_amp;
        for (int j = 1; j < DEPTH-1; j++)
        begin
            px_reg[j]    <= px_reg[j-1];
            py_reg[j]    <= py_reg[j-1];
            pz_reg[j]    <= pz_reg[j-1];
            total_reg[j] <= total_reg[j-1];
            asum_reg[j]  <= asum_reg[j-1];
            amp_reg[j]   <= amp_reg[j-1];
        end

        // stage 1: lattice cell, fraction, first hash
        for (int k = 0; k < 3; k++)
        begin
            tp_reg[0][k]  <= in_p[k][31-CELL_IDX -: FW];
            cell_reg[k]   <= in_p[k][39-CELL_IDX -: fgn_pkg::CELL_W];
            tsq_reg[k]    <= {16'b0, in_p[k][31-CELL_IDX -: FW]}
                           * {16'b0, in_p[k][31-CELL_IDX -: FW]};
        end
        for (int a = 0; a < 2; a++)
        begin
            ha_reg[a] <= fgn_pkg::PERM_ROM[8'(in_p[0][39-CELL_IDX -: 8] + 8'(a) + seed)];
        end
        for (int s = 1; s < 4; s++)
        begin
            tp_reg[s] <= tp_reg[s-1];
        end

        // stage 2
        for (int m = 0; m < 4; m++)
        begin
            hb_reg[m] <= fgn_pkg::PERM_ROM[8'(ha_reg[m/2] + cell_reg[1] + 8'(m%2))];
        end
        cz_reg <= cell_reg[2];
        for (int k = 0; k < 3; k++)
        begin
            q1_reg[k] <= fgn_pkg::fade_base(tp_reg[0][k], tsq_reg[k]);
        end

        // stage 3
        for (int m = 0; m < 8; m++)
        begin
            hc_reg[m] <= fgn_pkg::PERM_ROM[8'(hb_reg[m/2] + cz_reg + 8'(m%2))];
        end
        for (int k = 0; k < 3; k++)
        begin
            q2_reg[k] <= fgn_pkg::fade_step(q1_reg[k], tp_reg[1][k]);
        end

        // stage 4: corner dot products
        for (int m = 0; m < 8; m++)
        begin
            dot_reg[m] <= fgn_pkg::grad_dot(
                fgn_pkg::GSEL_ROM[hc_reg[m]],
                $signed({((m/4)%2 == 1) ? 2'b11 : 2'b00, tp_reg[2][0]}),
                $signed({((m/2)%2 == 1) ? 2'b11 : 2'b00, tp_reg[2][1]}),
                $signed({(m%2 == 1) ? 2'b11 : 2'b00, tp_reg[2][2]}));
        end
        for (int k = 0; k < 3; k++)
        begin
            q3_reg[k] <= fgn_pkg::fade_step(q2_reg[k], tp_reg[2][k]);
        end

        // stage 5
        for (int k = 0; k < 3; k++)
        begin
            f_reg[k] <= FW'(fgn_pkg::fade_step(q3_reg[k], tp_reg[3][k]));
        end
        dot5_reg <= dot_reg;

        // stage 6: blend along z
        for (int j = 0; j < 4; j++)
        begin
            bz_reg[j] <= fgn_pkg::blend(dot5_reg[2*j], dot5_reg[2*j+1], f_reg[2]);
        end
        fv_reg    <= f_reg[1];
        fu_reg[0] <= f_reg[0];

        // stage 7: blend along y
        for (int j = 0; j < 2; j++)
        begin
            by_reg[j] <= fgn_pkg::blend(bz_reg[2*j], bz_reg[2*j+1], fv_reg);
        end
        fu_reg[1] <= fu_reg[0];

        // stage 8: blend along x
        n_reg <= fgn_pkg::blend(by_reg[0], by_reg[1], fu_reg[1]);

        // stage 9: weighted accumulation
        out_px    <= px_reg[DEPTH-2];
        out_py    <= py_reg[DEPTH-2];
        out_pz    <= pz_reg[DEPTH-2];
        out_total <= total_next;
        out_asum  <= asum_next;
        out_amp   <= amp_next;
    end

    assign out_valid = vld_reg[DEPTH-1];

endmodule

### rtl/fgn_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_div_cell
// One restoring division step: decides one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgn_div_cell #(
    parameter int QBIT   = 15,
    parameter int TOT_W  = 37,
    parameter int ASUM_W = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [TOT_W-1:0]            in_rem,
    input  logic [ASUM_W-1:0]           in_div,
    input  logic [fgn_pkg::OUT_W-1:0]   in_quo,
    input  fgn_pkg::div_flags_t         in_flags,
    output logic                        out_valid,
    output logic [TOT_W-1:0]            out_rem,
    output logic [ASUM_W-1:0]           out_div,
    output logic [fgn_pkg::OUT_W-1:0]   out_quo,
    output fgn_pkg::div_flags_t         out_flags
);

    logic                      valid_reg;
    logic [TOT_W-1:0]          dsh;
    logic [TOT_W-1:0]          rem_next;
    logic [fgn_pkg::OUT_W-1:0] quo_next;

    always_comb
    begin
        dsh = TOT_W'(in_div) << QBIT;
        if (in_rem >= dsh)
        begin
            rem_next = in_rem - dsh;
            quo_next = in_quo | (fgn_pkg::OUT_W'(1) << QBIT);
        end
        else
        begin
            rem_next = in_rem;
            quo_next = in_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem   <= rem_next;
        out_div   <= in_div;
        out_quo   <= quo_next;
        out_flags <= in_flags;
    end

    assign out_valid = valid_reg;

endmodule

### rtl/fractal_gradient_noise_3d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_3d
// Fractal 3D gradient noise: a chain of octave cells followed by a chain of
// division cells that normalizes the weighted sum.
// ----------------------------------------------------------------------------
// start passes the input register, the octave cells, the divider front
// register, the divider cells and the output register before done
// throughput: one point per cycle; busy stays low, results cannot be stalled
// each octave cell has nine stages; one divider cell per quotient bit
// reset clears the valid bits and returns the config registers to defaults
module fractal_gradient_noise_3d #(
    parameter int MAX_OCTAVES = fgn_pkg::DEF_MAX_OCTAVES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [fgn_pkg::POS_W-1:0] pos_x,
    input  logic signed [fgn_pkg::POS_W-1:0] pos_y,
    input  logic signed [fgn_pkg::POS_W-1:0] pos_z,
    output logic                            done,
    output logic [fgn_pkg::OUT_W-1:0]       noise_level,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fgn_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fgn_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int TOT_W  = 34 + $clog2(MAX_OCTAVES);
    localparam int ASUM_W = 16 + $clog2(MAX_OCTAVES);
    localparam int PW     = fgn_pkg::PROD_W;
    localparam int OW     = fgn_pkg::OUT_W;

    logic [fgn_pkg::FREQ_W-1:0] base_frequency_reg;
    logic [fgn_pkg::AMP_W-1:0]  base_amplitude_reg;
    logic [fgn_pkg::CNT_W-1:0]  octave_count_reg;
    logic [fgn_pkg::GAIN_W-1:0] gain_per_octave_reg;
    logic [fgn_pkg::SEED_W-1:0] seed_byte_reg;

    logic [4:0]                 cnt_eff;
    logic [MAX_OCTAVES-1:0]     oct_on;

    logic                       in_valid_reg;
    logic [PW-1:0]              px_reg;
    logic [PW-1:0]              py_reg;
    logic [PW-1:0]              pz_reg;
    logic signed [56:0]         px_full;
    logic signed [56:0]         py_full;
    logic signed [56:0]         pz_full;

    logic                       ov_valid [MAX_OCTAVES+1];
    logic [PW-1:0]              ov_px    [MAX_OCTAVES+1];
    logic [PW-1:0]              ov_py    [MAX_OCTAVES+1];
    logic [PW-1:0]              ov_pz    [MAX_OCTAVES+1];
    logic [TOT_W-1:0]           ov_total [MAX_OCTAVES+1];
    logic [ASUM_W-1:0]          ov_asum  [MAX_OCTAVES+1];
    logic [fgn_pkg::AMP_W-1:0]  ov_amp   [MAX_OCTAVES+1];

    logic                       dv_valid [OW+1];
    logic [TOT_W-1:0]           dv_rem   [OW+1];
    logic [ASUM_W-1:0]          dv_div   [OW+1];
    logic [OW-1:0]              dv_quo   [OW+1];
    fgn_pkg::div_flags_t        dv_flags [OW+1];

    logic                       front_valid_reg;
    logic [TOT_W-1:0]           front_rem_reg;
    logic [ASUM_W-1:0]          front_div_reg;
    fgn_pkg::div_flags_t        front_flags_reg;
    fgn_pkg::div_flags_t        front_flags_next;

    logic                       done_reg;
    logic [OW-1:0]              noise_level_reg;
    logic [OW-1:0]              noise_level_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_frequency_reg  <= fgn_pkg::RST_BASE_FREQUENCY;
            base_amplitude_reg  <= fgn_pkg::RST_BASE_AMPLITUDE;
            octave_count_reg    <= fgn_pkg::RST_OCTAVE_COUNT;
            gain_per_octave_reg <= fgn_pkg::RST_GAIN_PER_OCTAVE;
            seed_byte_reg       <= fgn_pkg::RST_SEED_BYTE;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fgn_pkg::REG_BASE_FREQUENCY:  base_frequency_reg  <= cfg_data;
                fgn_pkg::REG_BASE_AMPLITUDE:  base_amplitude_reg  <= cfg_data[15:0];
                fgn_pkg::REG_OCTAVE_COUNT:    octave_count_reg    <= cfg_data[3:0];
                fgn_pkg::REG_GAIN_PER_OCTAVE: gain_per_octave_reg <= cfg_data[15:0];
                fgn_pkg::REG_SEED_BYTE:       seed_byte_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // octave enables
    always_comb
    begin
        if (octave_count_reg == '0)
        begin
            cnt_eff = 5'd1;
        end
        else if ({1'b0, octave_count_reg} > 5'(MAX_OCTAVES))
        begin
            cnt_eff = 5'(MAX_OCTAVES);
        end
        else
        begin
            cnt_eff = {1'b0, octave_count_reg};
        end
        for (int i = 0; i < MAX_OCTAVES; i++)
        begin
            oct_on[i] = 5'(i) < cnt_eff;
        end
    end

    // coordinate scaling by the base frequency
    assign px_full = pos_x * $signed({1'b0, base_frequency_reg});
    assign py_full = pos_y * $signed({1'b0, base_frequency_reg});
    assign pz_full = pos_z * $signed({1'b0, base_frequency_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_full[PW-1:0];
        py_reg <= py_full[PW-1:0];
        pz_reg <= pz_full[PW-1:0];
    end

    assign ov_valid[0] = in_valid_reg;
    assign ov_px[0]    = px_reg;
    assign ov_py[0]    = py_reg;
    assign ov_pz[0]    = pz_reg;
    assign ov_total[0] = '0;
    assign ov_asum[0]  = '0;
    assign ov_amp[0]   = base_amplitude_reg;

    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        fgn_octave_cell #(
            .CELL_IDX (i),
            .TOT_W    (TOT_W),
            .ASUM_W   (ASUM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (oct_on[i]),
            .seed      (seed_byte_reg),
            .gain      (gain_per_octave_reg),
            .in_valid  (ov_valid[i]),
            .in_px     (ov_px[i]),
            .in_py     (ov_py[i]),
            .in_pz     (ov_pz[i]),
            .in_total  (ov_total[i]),
            .in_asum   (ov_asum[i]),
            .in_amp    (ov_amp[i]),
            .out_valid (ov_valid[i+1]),
            .out_px    (ov_px[i+1]),
            .out_py    (ov_py[i+1]),
            .out_pz    (ov_pz[i+1]),
            .out_total (ov_total[i+1]),
            .out_asum  (ov_asum[i+1]),
            .out_amp   (ov_amp[i+1])
        );
    end

    // divider front: zero weight and saturation
    always_comb
    begin
        front_flags_next.zero = (ov_asum[MAX_OCTAVES] == '0);
        front_flags_next.sat  = ov_total[MAX_OCTAVES]
                              >= (TOT_W'(ov_asum[MAX_OCTAVES]) << OW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= ov_valid[MAX_OCTAVES];
        end
    end

    always_ff @(posedge clk)
    begin
        front_rem_reg   <= ov_total[MAX_OCTAVES];
        front_div_reg   <= ov_asum[MAX_OCTAVES];
        front_flags_reg <= front_flags_next;
    end

    assign dv_valid[0] = front_valid_reg;
    assign dv_rem[0]   = front_rem_reg;
    assign dv_div[0]   = front_div_reg;
    assign dv_quo[0]   = '0;
    assign dv_flags[0] = front_flags_reg;

    for (genvar k = 0; k < OW; k++)
    begin : g_div
        fgn_div_cell #(
            .QBIT   (OW-1-k),
            .TOT_W  (TOT_W),
            .ASUM_W (ASUM_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[k]),
            .in_rem    (dv_rem[k]),
            .in_div    (dv_div[k]),
            .in_quo    (dv_quo[k]),
            .in_flags  (dv_flags[k]),
            .out_valid (dv_valid[k+1]),
            .out_rem   (dv_rem[k+1]),
            .out_div   (dv_div[k+1]),
            .out_quo   (dv_quo[k+1]),
            .out_flags (dv_flags[k+1])
        );
    end

    always_comb
    begin
        if (dv_flags[OW].zero)
        begin
            noise_level_next = '0;
        end
        else if (dv_flags[OW].sat)
        begin
            noise_level_next = '1;
        end
        else
        begin
            noise_level_next = dv_quo[OW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[OW];
        end
    end

    always_ff @(posedge clk)
    begin
        noise_level_reg <= noise_level_next;
    end

    assign done        = done_reg;
    assign noise_level = noise_level_reg;

    // remainder of the last step is not needed
    logic unused_rem;
    assign unused_rem = ^{dv_rem[OW], dv_div[OW], ov_amp[MAX_OCTAVES],
                          ov_px[MAX_OCTAVES], ov_py[MAX_OCTAVES], ov_pz[MAX_OCTAVES]};

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal gradient noise testbench
// Drives 3D points into the noise pipeline under several register settings
// and random request gaps, predicts each noise level independently and
// compares every result in order against the scoreboard.
// ----------------------------------------------------------------------------
class noise_scoreboard;
    logic [15:0] expected_q[$];
    int          mismatches;
    int          checked;

    function void note_request(logic [15:0] level);
        expected_q.push_back(level);
    endfunction

    function void check_result(logic [15:0] level);
        logic [15:0] want;
        if (expected_q.size() == 0)
        begin
            $error("noise_level: unexpected result %0d", level);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (want !== level)
        begin
            $error("noise_level: expected %0d, actual %0d", want, level);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;

    localparam int LATENCY = 9 * fgn_pkg::DEF_MAX_OCTAVES + 19;

    // indexes past the register list
    localparam logic [fgn_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [fgn_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic signed [fgn_pkg::POS_W-1:0] pos_x = '0;
    logic signed [fgn_pkg::POS_W-1:0] pos_y = '0;
    logic signed [fgn_pkg::POS_W-1:0] pos_z = '0;
    logic                             done;
    logic [fgn_pkg::OUT_W-1:0]        noise_level;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [fgn_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [fgn_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    logic [fgn_pkg::FREQ_W-1:0] m_freq = fgn_pkg::RST_BASE_FREQUENCY;
    logic [fgn_pkg::AMP_W-1:0]  m_amp = fgn_pkg::RST_BASE_AMPLITUDE;
    logic [fgn_pkg::CNT_W-1:0]  m_count = fgn_pkg::RST_OCTAVE_COUNT;
    logic [fgn_pkg::GAIN_W-1:0] m_gain = fgn_pkg::RST_GAIN_PER_OCTAVE;
    logic [fgn_pkg::SEED_W-1:0] m_seed = fgn_pkg::RST_SEED_BYTE;

    noise_scoreboard sb = new();
    int gap_pct = 0;
    int settings_run = 0;

    const int grad_x[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    const int grad_y[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};
    const int grad_z[12] = '{0, 0, 0, 0, 1, 1, -1, -1, 1, 1, -1, -1};

    fractal_gradient_noise_3d dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .noise_level(noise_level),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] quintic_fade(logic [15:0] t);
        logic [63:0] q;
        logic [63:0] tt;
        tt = {48'b0, t};
        q = (64'd10 << 32) + 64'd6 * tt * tt - 64'd15 * tt * 64'd65536;
        q = q >> 16;
        q = (q * tt) >> 16;
        q = (q * tt) >> 16;
        q = (q * tt) >> 16;
        return q[31:0];
    endfunction

    function automatic longint mix(longint a, longint b, logic [31:0] w);
        return a + (((b - a) * longint'({32'b0, w})) >>> 16);
    endfunction

    function automatic logic [15:0] predict_noise(logic [31:0] px, logic [31:0] py,
                                                  logic [31:0] pz);
        logic [63:0] pos[3];
        logic [63:0] p;
        logic [63:0] freq;
        logic [63:0] amp;
        logic [63:0] total;
        logic [63:0] amp_sum;
        logic [63:0] res;
        logic [7:0]  lattice[3];
        logic [15:0] frac[3];
        logic [7:0]  ha, hb, hc;
        longint      n[8];
        longint      d;
        int          sel;
        int          cnt;
        pos[0] = {{32{px[31]}}, px};
        pos[1] = {{32{py[31]}}, py};
        pos[2] = {{32{pz[31]}}, pz};
        cnt = (m_count == 0) ? 1 : (m_count > fgn_pkg::DEF_MAX_OCTAVES) ?
              fgn_pkg::DEF_MAX_OCTAVES : m_count;
        amp = {48'b0, m_amp};
        total = 0;
        amp_sum = 0;
        for (int i = 0; i < cnt; i++)
        begin
            freq = {40'b0, m_freq} << i;
            for (int k = 0; k < 3; k++)
            begin
                p = pos[k] * freq;
                lattice[k] = p[39:32];
                frac[k] = p[31:16];
            end
            for (int a = 0; a < 2; a++)
            begin
                ha = fgn_pkg::PERM_ROM[8'(lattice[0] + a + m_seed)];
                for (int b = 0; b < 2; b++)
                begin
                    hb = fgn_pkg::PERM_ROM[8'(ha + lattice[1] + b)];
                    for (int c = 0; c < 2; c++)
                    begin
                        hc = fgn_pkg::PERM_ROM[8'(hb + lattice[2] + c)];
                        sel = fgn_pkg::GSEL_ROM[hc] % 12;
                        n[a*4 + b*2 + c] =
                            grad_x[sel] * (longint'(frac[0]) - a * 65536)
                          + grad_y[sel] * (longint'(frac[1]) - b * 65536)
                          + grad_z[sel] * (longint'(frac[2]) - c * 65536);
                    end
                end
            end
            d = mix(mix(mix(n[0], n[1], quintic_fade(frac[2])),
                        mix(n[2], n[3], quintic_fade(frac[2])), quintic_fade(frac[1])),
                    mix(mix(n[4], n[5], quintic_fade(frac[2])),
                        mix(n[6], n[7], quintic_fade(frac[2])), quintic_fade(frac[1])),
                    quintic_fade(frac[0]));
            if (d < 0)
                d = -d;
            total += 64'(d) * amp;
            amp_sum += amp;
            amp = (amp * {48'b0, m_gain}) >> 16;
        end
        res = (amp_sum == 0) ? 64'd0 : total / amp_sum;
        if (res > 64'd65535)
            res = 64'd65535;
        return res[15:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_request(predict_noise(pos_x, pos_y, pos_z));
        if (rst_n && done)
            sb.check_result(noise_level);
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fgn_pkg::REG_BASE_FREQUENCY:  m_freq <= cfg_data[fgn_pkg::FREQ_W-1:0];
                fgn_pkg::REG_BASE_AMPLITUDE:  m_amp <= cfg_data[fgn_pkg::AMP_W-1:0];
                fgn_pkg::REG_OCTAVE_COUNT:    m_count <= cfg_data[fgn_pkg::CNT_W-1:0];
                fgn_pkg::REG_GAIN_PER_OCTAVE: m_gain <= cfg_data[fgn_pkg::GAIN_W-1:0];
                fgn_pkg::REG_SEED_BYTE:       m_seed <= cfg_data[fgn_pkg::SEED_W-1:0];
                default: ;
            endcase
        end
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_reg(logic [fgn_pkg::CFG_IDX_W-1:0] idx,
                             logic [fgn_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [23:0] freq, logic [15:0] amp, logic [3:0] cnt,
                                 logic [15:0] gain, logic [7:0] seed);
        drain();
        write_reg(fgn_pkg::REG_BASE_FREQUENCY, freq);
        write_reg(fgn_pkg::REG_BASE_AMPLITUDE, {8'b0, amp});
        write_reg(fgn_pkg::REG_OCTAVE_COUNT, {20'b0, cnt});
        write_reg(fgn_pkg::REG_GAIN_PER_OCTAVE, {8'b0, gain});
        write_reg(fgn_pkg::REG_SEED_BYTE, {16'b0, seed});
        @(posedge clk);
        settings_run++;
    endtask

    task automatic random_points(int count);
        logic [31:0] v[3];
        for (int i = 0; i < count; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                case ($urandom_range(3))
                    0: v[k] = $urandom();
                    1: v[k] = 32'($signed($urandom_range(2097152)) - 1048576);
                    2: v[k] = {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
                    default: v[k] = {16'($urandom_range(255)), 16'($urandom())};
                endcase
            end
            send_point(v[0], v[1], v[2]);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners at reset settings
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'hffffffff, 32'h0000ffff, 32'h00010000);
        send_point(32'h00008000, 32'h00008000, 32'h00008000);
        send_point(32'hffff8000, 32'h00ff0001, 32'hff00ffff);
        send_point(32'h55555555, 32'haaaaaaaa, 32'h12345678);
        send_point(32'haaaaaaaa, 32'h55555555, 32'hedcba987);
        drain();
        write_reg(REG_SPARE_LO, 24'hffffff);
        write_reg(REG_SPARE_HI, 24'h000001);

        // extremes of every register
        apply_setting(24'hffffff, 16'hffff, 4'd8, 16'hffff, 8'hff);
        send_point(32'h7fffffff, 32'h80000000, 32'h00012345);
        send_point(32'h00003333, 32'hffffcccc, 32'h7fff0001);
        apply_setting(24'd0, 16'd1, 4'd1, 16'd0, 8'd0);
        send_point(32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
        apply_setting(24'd65536, 16'd4096, 4'd0, 16'd32768, 8'd17);
        send_point(32'h00018000, 32'h00024000, 32'h0003c000);
        apply_setting(24'd98304, 16'd40000, 4'd15, 16'd65535, 8'd200);
        send_point(32'h00018000, 32'h00024000, 32'h0003c000);
        apply_setting(24'd65536, 16'd0, 4'd3, 16'd32768, 8'd1);
        send_point(32'h00018000, 32'h00024000, 32'h0003c000);
        apply_setting(24'd65536, 16'hffff, 4'd1, 16'd0, 8'd0);
        send_point(32'h00004000, 32'h0000c000, 32'h00002000);
        send_point(32'hdeadbeef, 32'h00000001, 32'hfffffffe);

        gap_pct = 32;
        apply_setting(fgn_pkg::RST_BASE_FREQUENCY, fgn_pkg::RST_BASE_AMPLITUDE,
                      fgn_pkg::RST_OCTAVE_COUNT, fgn_pkg::RST_GAIN_PER_OCTAVE,
                      fgn_pkg::RST_SEED_BYTE);
        random_points(70);
        apply_setting(24'($urandom()), 16'($urandom_range(65535, 1)), 4'($urandom_range(8, 1)),
                      16'($urandom()), 8'($urandom()));
        random_points(60);

        gap_pct = 66;
        apply_setting(24'hffffff, 16'd1, 4'd8, 16'hffff, 8'hff);
        random_points(60);
        apply_setting(24'($urandom_range(262144)), 16'($urandom()), 4'($urandom()),
                      16'($urandom()), 8'($urandom()));
        random_points(60);

        gap_pct = 0;
        apply_setting(24'd0, 16'($urandom_range(65535, 1)), 4'd2, 16'd65535, 8'($urandom()));
        random_points(40);
        apply_setting(24'($urandom()), 16'($urandom()), 4'($urandom_range(8, 1)),
                      16'($urandom()), 8'($urandom()));
        random_points(60);
        // pause until every result is back, then resume
        start <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        random_points(60);

        drain();
        $display("covered %0d noise results over %0d register settings", sb.checked,
                 settings_run + 1);
        $display("gaps of 32%% and 66%% and back-to-back requests were exercised");
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
